@@ rtl/trajectory_lookahead_ratio_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the lookahead ratio unit
// Simulation checks; they compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef TRAJECTORY_LOOKAHEAD_RATIO_UNIT_DEFINES_SVH
`define TRAJECTORY_LOOKAHEAD_RATIO_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TLR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define TLR_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define TLR_ASSERT(label, clk, rst, prop)
`define TLR_ASSERT_NR(label, clk, prop)
`endif
`endif

@@ rtl/tlr_pkg.sv @@
// ----------------------------------------------------------------------------
// Lookahead ratio package
// Shared types, constants and command structs.
// ----------------------------------------------------------------------------
package tlr_pkg;
  localparam int MaxPointsDefault = 1024;
  localparam logic [14:0] RstThreshold = 15'd2458;
  localparam logic [14:0] RstMinAngle = 15'd860;
  localparam logic [14:0] RstMaxAngle = 15'd1434;
  localparam logic [14:0] RstStep = 15'd164;
  localparam logic [15:0] RatioOne = 16'd16384;

  localparam logic [1:0] RegThreshold = 2'd0;
  localparam logic [1:0] RegMinAngle = 2'd1;
  localparam logic [1:0] RegMaxAngle = 2'd2;
  localparam logic [1:0] RegStep = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_RDWAIT, ST_DIST, ST_DECIDE, ST_SELRD, ST_SELWAIT,
    ST_DIFF, ST_RATIO, ST_NOTRAJ, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;      // write word into table
    logic capture;   // latch query angles
    logic rd_cur;    // read entry at walk index
    logic rd_sel;    // read final entry
    logic measure;   // compute distance on read data
    logic diff;      // capture diffs of selected entry
    logic ratio_init;
    logic ratio_step;
    logic empty;     // produce no-trajectory result
    logic commit;    // update walk state and result
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic no_traj;
    logic walk_end;  // walk index reached point count
    logic far;       // distance reached threshold
    logic stop;      // ratio loop stops here
    logic done_all;
  } stat_t;
endpackage

@@ rtl/tlr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Lookahead ratio controller
// Sequences the waypoint walk and the ratio loop.
// ----------------------------------------------------------------------------
`include "trajectory_lookahead_ratio_unit_defines.svh"
module tlr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           out_busy,
  input  tlr_pkg::stat_t st,
  output tlr_pkg::cmd_t  cmd,
  output logic           in_stall_c,
  output logic           out_set
);
  tlr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= tlr_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    out_set = 1'b0;
    in_stall_c = (state != tlr_pkg::ST_IDLE);
    case (state)
      tlr_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          if (!st.is_query) cmd.load = 1'b1;
          else state_next = tlr_pkg::ST_RD;
        end
      end
      tlr_pkg::ST_RD: begin
        if (st.no_traj) state_next = tlr_pkg::ST_NOTRAJ;
        else if (st.walk_end) state_next = tlr_pkg::ST_SELRD;
        else begin
          cmd.rd_cur = 1'b1;
          state_next = tlr_pkg::ST_RDWAIT;
        end
      end
      tlr_pkg::ST_RDWAIT: state_next = tlr_pkg::ST_DIST;
      tlr_pkg::ST_DIST: begin
        cmd.measure = 1'b1;
        state_next = tlr_pkg::ST_DECIDE;
      end
      tlr_pkg::ST_DECIDE: begin
        // hit: data already holds the chosen entry
        if (st.far) state_next = tlr_pkg::ST_DIFF;
        else state_next = tlr_pkg::ST_RD;
      end
      tlr_pkg::ST_SELRD: begin
        cmd.rd_sel = 1'b1;
        state_next = tlr_pkg::ST_SELWAIT;
      end
      tlr_pkg::ST_SELWAIT: state_next = tlr_pkg::ST_DIFF;
      tlr_pkg::ST_DIFF: begin
        cmd.diff = 1'b1;
        cmd.ratio_init = 1'b1;
        state_next = tlr_pkg::ST_RATIO;
      end
      tlr_pkg::ST_RATIO: begin
        if (st.done_all || st.stop) begin
          if (!out_busy) begin
            cmd.commit = 1'b1;
            out_set = 1'b1;
            state_next = tlr_pkg::ST_IDLE;
          end
        end else cmd.ratio_step = 1'b1;
      end
      tlr_pkg::ST_NOTRAJ: begin
        if (!out_busy) begin
          cmd.empty = 1'b1;
          out_set = 1'b1;
          state_next = tlr_pkg::ST_IDLE;
        end
      end
      default: state_next = tlr_pkg::ST_IDLE;
    endcase
  end

  `TLR_ASSERT(a_busy_no_accept, clk, rst, (state != tlr_pkg::ST_IDLE) |-> !in_fire)
  `TLR_ASSERT(a_out_idle, clk, rst, out_set |=> (state == tlr_pkg::ST_IDLE))
  `TLR_ASSERT(a_cmd_excl, clk, rst, $onehot0({cmd.rd_cur, cmd.rd_sel, cmd.load}))
endmodule

@@ rtl/tlr_datapath.sv @@
// ----------------------------------------------------------------------------
// Lookahead ratio datapath
// Waypoint memory, distance unit, ratio stepper and walk state.
// ----------------------------------------------------------------------------
module tlr_datapath #(
  parameter int MaxPoints = tlr_pkg::MaxPointsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  tlr_pkg::cmd_t      cmd,
  output tlr_pkg::stat_t     st,
  input  logic               mode,
  input  logic               first_point,
  input  logic signed [15:0] ang_in [6],
  input  logic [14:0]        dist_threshold,
  input  logic [14:0]        min_angle,
  input  logic [14:0]        max_angle,
  input  logic [14:0]        step_size,
  output logic signed [15:0] tgt [6],
  output logic [14:0]        ratio,
  output logic [10:0]        next_index,
  output logic               active,
  output logic               finished
);
  localparam int AW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int CW = $clog2(MaxPoints + 1);

  logic [95:0] mem [MaxPoints];
  logic [95:0] rdata;
  logic [CW-1:0] point_count, cur_index, walk;
  logic traj_loaded;
  logic signed [15:0] cur [6];
  logic [16:0] dif [6];
  logic [16:0] k;
  logic far_r;
  logic [CW-1:0] cnt_ld;
  logic [AW-1:0] rd_addr;
  logic [36:0] dsum;
  logic [35:0] thr2;
  logic [32:0] lim_max, lim_min;
  logic lo_max, lo_min, hi_max, lo_small, done_all;
  logic [14:0] step;
  logic [16:0] k_sat;

  // load: first_point restarts the table
  assign cnt_ld = first_point ? '0 : point_count;

  always_ff @(posedge clk) begin
    if (cmd.load && cnt_ld < CW'(MaxPoints))
      mem[cnt_ld[AW-1:0]] <= {ang_in[5], ang_in[4], ang_in[3], ang_in[2], ang_in[1], ang_in[0]};
    if (cmd.rd_cur || cmd.rd_sel) rdata <= mem[rd_addr];
  end

  assign rd_addr = cmd.rd_sel ? AW'(point_count - CW'(1)) : walk[AW-1:0];

  always_comb begin
    logic signed [16:0] d;
    logic [33:0] sq5, sq1;
    sq5 = '0;
    sq1 = '0;
    for (int j = 0; j < 6; j++) begin
      d = 17'(cur[j]) - 17'($signed(rdata[16*j +: 16]));
      if (j == 3 || j == 5) sq1 = sq1 + 34'($unsigned(34'(d) * 34'(d)));
      else sq5 = sq5 + 34'($unsigned(34'(d) * 34'(d)));
    end
    dsum = 37'(sq5) * 37'd5 + 37'(sq1);
  end
  assign thr2 = 36'(dist_threshold) * 36'(dist_threshold) * 36'd5;

  assign lim_max = 33'({max_angle, 14'd0});
  assign lim_min = 33'({min_angle, 14'd0});
  always_comb begin
    lo_max = 1'b0; lo_min = 1'b0; hi_max = 1'b0; done_all = 1'b1;
    for (int j = 0; j < 6; j++) begin
      if (j < 3) begin
        if (34'(dif[j]) * 34'(k) > 34'(lim_max)) lo_max = 1'b1;
        if (34'(dif[j]) * 34'(k) > 34'(lim_min)) lo_min = 1'b1;
      end else if (34'(dif[j]) * 34'(k) > 34'(lim_max)) hi_max = 1'b1;
      if (dif[j] > 17'(min_angle)) done_all = 1'b0;
    end
    lo_small = (dif[0] < 17'(min_angle)) && (dif[1] < 17'(min_angle)) &&
               (dif[2] < 17'(min_angle));
  end
  assign step = (step_size == '0) ? 15'd1 : step_size;
  assign k_sat = (k > 17'd32767) ? 17'd32767 : k;

  assign st.is_query = mode;
  assign st.no_traj = !traj_loaded || point_count == '0;
  assign st.walk_end = walk >= point_count;
  assign st.far = far_r;
  assign st.done_all = done_all;
  assign st.stop = (k > 17'(tlr_pkg::RatioOne)) || lo_max ||
                   (hi_max && (lo_min || lo_small));

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      cur_index <= '0;
      traj_loaded <= 1'b0;
    end else begin
      if (cmd.load) begin
        point_count <= (cnt_ld < CW'(MaxPoints)) ? cnt_ld + CW'(1) : cnt_ld;
        if (first_point) cur_index <= '0;
        traj_loaded <= 1'b1;
      end
      if (cmd.commit) begin
        if (done_all && (far_r ? walk + CW'(1) : point_count) == point_count) begin
          cur_index <= '0;
          traj_loaded <= 1'b0;
        end else cur_index <= far_r ? walk + CW'(1) : point_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= ang_in;
      walk <= cur_index;
      far_r <= 1'b0;
    end
    if (cmd.measure) begin
      far_r <= 37'(thr2) <= dsum;
      if (37'(thr2) > dsum) walk <= walk + CW'(1);
    end
    if (cmd.diff)
      for (int j = 0; j < 6; j++) begin
        logic signed [16:0] d;
        d = 17'($signed(rdata[16*j +: 16])) - 17'(cur[j]);
        dif[j] <= d[16] ? 17'(-d) : 17'(d);
      end
    if (cmd.ratio_init) k <= 17'(step);
    if (cmd.ratio_step) k <= k + 17'(step);
    if (cmd.commit) begin
      for (int j = 0; j < 6; j++) tgt[j] <= $signed(rdata[16*j +: 16]);
      ratio <= done_all ? tlr_pkg::RatioOne[14:0] : k_sat[14:0];
      active <= 1'b1;
      if (done_all && (far_r ? walk + CW'(1) : point_count) == point_count) begin
        next_index <= '0;
        finished <= 1'b1;
      end else begin
        next_index <= 11'(far_r ? walk + CW'(1) : point_count);
        finished <= 1'b0;
      end
    end
    if (cmd.empty) begin
      for (int j = 0; j < 6; j++) tgt[j] <= '0;
      ratio <= tlr_pkg::RatioOne[14:0];
      next_index <= 11'(cur_index);
      active <= 1'b0;
      finished <= 1'b0;
    end
  end
endmodule

@@ rtl/trajectory_lookahead_ratio_unit.sv @@
// Operation: a load is written into the table when taken; a query reads, measures and tests
// each waypoint of the walk in turn, reads the last waypoint when none is far enough, then
// tries ratio values (at most 16384/step_size + 1); with no trajectory a query gives an empty result.
// Throughput: one item at a time; the next item can be taken in the cycle after the result word
// is set, and a stalled result word holds the query in its last state.
// Reset: synchronous; clears point count, walk index and loaded flag, reloads config defaults.
// ----------------------------------------------------------------------------
// Trajectory lookahead ratio unit
// Top level: configuration registers, output holding register, ctrl and datapath.
// ----------------------------------------------------------------------------
`include "trajectory_lookahead_ratio_unit_defines.svh"
module trajectory_lookahead_ratio_unit #(
  parameter int MaxPoints = tlr_pkg::MaxPointsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic               first_point,
  input  logic signed [15:0] ang_a1, ang_a2, ang_a3, ang_a4, ang_a5, ang_a6,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] tgt_a1, tgt_a2, tgt_a3, tgt_a4, tgt_a5, tgt_a6,
  output logic [14:0]        ratio,
  output logic [10:0]        next_index,
  output logic               active,
  output logic               finished,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);
  tlr_pkg::cmd_t cmd;
  tlr_pkg::stat_t st;
  logic in_fire, stall_c, out_set;
  logic [14:0] dist_threshold, min_angle, max_angle, step_size;
  logic signed [15:0] ang [6];
  logic signed [15:0] tgt [6];

  assign ang = '{ang_a1, ang_a2, ang_a3, ang_a4, ang_a5, ang_a6};
  assign {tgt_a1, tgt_a2, tgt_a3, tgt_a4, tgt_a5, tgt_a6} =
         {tgt[0], tgt[1], tgt[2], tgt[3], tgt[4], tgt[5]};
  assign in_stall = stall_c;
  assign in_fire = in_valid && !stall_c;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_threshold <= tlr_pkg::RstThreshold;
      min_angle <= tlr_pkg::RstMinAngle;
      max_angle <= tlr_pkg::RstMaxAngle;
      step_size <= tlr_pkg::RstStep;
    end else if (cfg_valid) begin
      case (cfg_index)
        tlr_pkg::RegThreshold: dist_threshold <= cfg_data;
        tlr_pkg::RegMinAngle: min_angle <= cfg_data;
        tlr_pkg::RegMaxAngle: max_angle <= cfg_data;
        tlr_pkg::RegStep: step_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold word until taken
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_set) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  tlr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(out_valid && out_stall),
    .st(st), .cmd(cmd), .in_stall_c(stall_c), .out_set(out_set)
  );

  tlr_datapath #(.MaxPoints(MaxPoints)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st), .mode(mode), .first_point(first_point),
    .ang_in(ang), .dist_threshold(dist_threshold), .min_angle(min_angle),
    .max_angle(max_angle), .step_size(step_size), .tgt(tgt), .ratio(ratio),
    .next_index(next_index), .active(active), .finished(finished)
  );

  `TLR_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> out_valid && $stable(ratio))
  `TLR_ASSERT(a_no_set_busy, clk, rst, (out_valid && out_stall) |-> !out_set)
  `TLR_ASSERT_NR(a_rst_idle, clk, rst |=> !out_valid)
endmodule
